// ===== rtl/hsmt_pkg.sv =====
// Package for the heard-station move-to-front tables.
// Holds the entry type, result codes and the callsign and match helpers.
// Depends on nothing.
package hsmt_pkg;

   localparam int AddrWidth  = 56;
   localparam int IfaceWidth = 4;
   localparam int CountWidth = 32;
   localparam int TimeWidth  = 32;
   localparam int UsedWidth  = 6;
   localparam int CallBytes  = 6;

   // Link-address bits that take part in the compare: bytes 0..5 and the SSID bits.
   localparam logic [AddrWidth-1:0] MatchMask = 56'h1E_FFFF_FFFF_FFFF;

   // Result codes.
   localparam logic [2:0] StatusFiltered = 3'd0;
   localparam logic [2:0] StatusInvalid  = 3'd1;
   localparam logic [2:0] StatusHit      = 3'd2;
   localparam logic [2:0] StatusNew      = 3'd3;
   localparam logic [2:0] StatusReplace  = 3'd4;

   // Register indexes of the write port.
   localparam logic [1:0] RegSkipSource = 2'd0;
   localparam logic [1:0] RegSkipDest   = 2'd1;
   localparam logic [1:0] RegIfaceMask  = 2'd2;
   localparam logic [1:0] RegMaxEntries = 2'd3;

   typedef struct packed {
      logic [AddrWidth-1:0]  addr;
      logic [IfaceWidth-1:0] iface;
      logic [CountWidth-1:0] count;
      logic [TimeWidth-1:0]  stamp;
   } entry_type;

   // Each of the first six bytes, shifted right one, must be A-Z, 0-9 or a space.
   function automatic logic valid_call(input logic [AddrWidth-1:0] a);
      logic       ok;
      logic [6:0] c;
      ok = 1'b1;
      for (int k = 0; k < CallBytes; k++) begin
         c = a[8*k+1 +: 7];
         if (!((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h30 && c <= 7'h39) || c == 7'h20))
            ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic addr_match(input logic [AddrWidth-1:0] a,
                                       input logic [AddrWidth-1:0] b);
      return ((a ^ b) & MatchMask) == '0;
   endfunction

endpackage

// ===== rtl/hsmt_entry_ram.sv =====
// Synchronous single-port-write, single-port-read entry memory.
// Read data is registered. Depends on hsmt_pkg.
module hsmt_entry_ram #(
   parameter int AW = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  hsmt_pkg::entry_type   wr_data,
   input  logic [AW-1:0]         rd_addr,
   output hsmt_pkg::entry_type   rd_data
);

   hsmt_pkg::entry_type mem [0:(1<<AW)-1];
   hsmt_pkg::entry_type rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/heard_station_mtf_table_unit.sv =====
// Top level of the heard-station move-to-front tables.
// Depends on hsmt_pkg and hsmt_entry_ram.
//
// Usage: a command is transferred at a clock edge with start high and busy
// low. Its fields are req_cmd (0 source table, 1 destination table),
// req_iface_id, req_station_addr and req_now_seconds. Exactly one result is
// returned on rsp_status, rsp_heard_count and rsp_entries_used, shown for a
// single cycle with rsp_strobe; the receiver cannot stall it.
// A filtered or invalid command answers in the cycle after its transfer and
// busy stays low. Otherwise the unit walks its recency list, one entry per
// cycle through the entry memory (one read port, registered read data):
// a hit ends the walk at its entry, a miss reads all entries, and an empty
// table skips the walk. The entry is then written and the result registered.
// busy is high for the whole walk and update.
// The write port (csr_*) sets the four registers; write it only while idle.
// Reset clears the registers and both entry counts; memory contents need no
// clearing since only entries below the count are ever used.
module heard_station_mtf_table_unit #(
   parameter int TABLE_ENTRIES = 32,
   parameter int NUM_IFACES    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [3:0]  req_iface_id,
   input  logic [55:0] req_station_addr,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_heard_count,
   output logic [5:0]  rsp_entries_used,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int RW = $clog2(TABLE_ENTRIES + 1);
   localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SRCH  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   // Registers.
   logic        skip_src_ff, skip_dst_ff;
   logic [15:0] mask_ff;
   logic [5:0]  max_ff;

   logic [1:0]  state_ff, state_in;
   logic [RW-1:0] used_ff [2];
   logic [SW-1:0] order_ff [2][TABLE_ENTRIES];

   logic          cmd_ff;
   logic [3:0]    iface_ff;
   logic [55:0]   addr_ff;
   logic [31:0]   now_ff;
   logic [RW-1:0] rank_ff;
   logic [RW-1:0] cmp_rank_ff;
   logic          rd_pend_ff;
   logic [SW-1:0] rd_slot_ff;
   logic [RW-1:0] h_ff;
   logic [SW-1:0] slot_ff;
   logic          grow_ff;
   logic [2:0]    status_ff;
   hsmt_pkg::entry_type ent_ff;

   logic        strobe_ff;
   logic [2:0]  out_status_ff;
   logic [31:0] out_count_ff;
   logic [5:0]  out_used_ff;

   // Memory interface.
   hsmt_pkg::entry_type rd_data, wr_data;
   logic [SW:0]         rd_addr, wr_addr;
   logic [SW-1:0]       issue_slot;

   // Decoding of the incoming command.
   logic          logging, skipped, accept;
   logic [RW-1:0] n_req, n_cur, limit;
   logic          rd_hit, rd_last;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign logging = (32'(req_iface_id) < NUM_IFACES) && mask_ff[req_iface_id];
   assign skipped = req_cmd ? skip_dst_ff : skip_src_ff;
   assign n_req   = used_ff[req_cmd];
   assign n_cur   = used_ff[cmd_ff];
   assign limit   = (max_ff == 6'd0 || 32'(max_ff) > TABLE_ENTRIES)
                    ? RW'(TABLE_ENTRIES) : RW'(max_ff);

   assign issue_slot = order_ff[cmd_ff][rank_ff[SW-1:0]];
   assign rd_addr    = {cmd_ff, issue_slot};
   assign rd_hit  = rd_pend_ff && rd_data.iface == iface_ff
                    && hsmt_pkg::addr_match(rd_data.addr, addr_ff);
   assign rd_last = rd_pend_ff && (cmp_rank_ff == n_cur - RW'(1));

   assign wr_addr = {cmd_ff, slot_ff};
   assign wr_data = '{addr: ent_ff.addr, iface: ent_ff.iface,
                      count: ent_ff.count, stamp: now_ff};

   hsmt_entry_ram #(.AW(SW + 1)) u_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_WRITE),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !skipped && logging && hsmt_pkg::valid_call(req_station_addr))
               state_in = (n_req == '0) ? ST_WRITE : ST_SRCH;
         end
         ST_SRCH: begin
            if (rd_hit || rd_last)
               state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         skip_src_ff <= 1'b0;
         skip_dst_ff <= 1'b0;
         mask_ff     <= '0;
         max_ff      <= '0;
         used_ff[0]  <= '0;
         used_ff[1]  <= '0;
         strobe_ff   <= 1'b0;
         rd_pend_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               hsmt_pkg::RegSkipSource: skip_src_ff <= csr_wdata[0];
               hsmt_pkg::RegSkipDest:   skip_dst_ff <= csr_wdata[0];
               hsmt_pkg::RegIfaceMask:  mask_ff     <= csr_wdata;
               hsmt_pkg::RegMaxEntries: max_ff      <= csr_wdata[5:0];
               default: ;
            endcase
         end
         // A read is pending for every rank issued below the count.
         rd_pend_ff <= (state_ff == ST_SRCH) && (rank_ff < n_cur);
         if (state_ff == ST_IDLE && accept
             && (skipped || !logging || !hsmt_pkg::valid_call(req_station_addr))) begin
            strobe_ff <= 1'b1;
         end
         if (state_ff == ST_WRITE) begin
            strobe_ff <= 1'b1;
            if (grow_ff)
               used_ff[cmd_ff] <= n_cur + RW'(1);
         end
      end
   end

   // Payload: command capture, list walk and result.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff   <= req_cmd;
            iface_ff <= req_iface_id;
            addr_ff  <= req_station_addr;
            now_ff   <= req_now_seconds;
            rank_ff  <= '0;
            // Empty table: a new entry in slot zero.
            h_ff     <= '0;
            slot_ff  <= '0;
            grow_ff  <= 1'b1;
            status_ff <= hsmt_pkg::StatusNew;
            ent_ff   <= '{addr: req_station_addr, iface: req_iface_id,
                          count: 32'd1, stamp: req_now_seconds};
            if (accept) begin
               out_status_ff <= skipped || !logging ? hsmt_pkg::StatusFiltered
                                                    : hsmt_pkg::StatusInvalid;
               out_count_ff  <= '0;
               out_used_ff   <= 6'(n_req);
            end
         end
         ST_SRCH: begin
            if (rank_ff < n_cur)
               rank_ff <= rank_ff + RW'(1);
            cmp_rank_ff <= rank_ff;
            rd_slot_ff  <= issue_slot;
            if (rd_hit) begin
               h_ff      <= cmp_rank_ff;
               slot_ff   <= rd_slot_ff;
               grow_ff   <= 1'b0;
               status_ff <= hsmt_pkg::StatusHit;
               ent_ff    <= '{addr: rd_data.addr, iface: rd_data.iface,
                              count: rd_data.count + 32'd1, stamp: now_ff};
            end else if (rd_last) begin
               if (n_cur >= limit) begin
                  // Full: the least recent slot is reused.
                  h_ff      <= n_cur - RW'(1);
                  slot_ff   <= rd_slot_ff;
                  grow_ff   <= 1'b0;
                  status_ff <= hsmt_pkg::StatusReplace;
               end else begin
                  h_ff      <= n_cur;
                  slot_ff   <= n_cur[SW-1:0];
                  grow_ff   <= 1'b1;
                  status_ff <= hsmt_pkg::StatusNew;
               end
               ent_ff <= '{addr: addr_ff, iface: iface_ff, count: 32'd1, stamp: now_ff};
            end
         end
         ST_WRITE: begin
            out_status_ff <= status_ff;
            out_count_ff  <= ent_ff.count;
            out_used_ff   <= 6'(grow_ff ? n_cur + RW'(1) : n_cur);
         end
         default: ;
      endcase
   end

   // Recency list: ranks in front of the moved one shift back by one, slot goes to the front.
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         for (int i = 1; i < TABLE_ENTRIES; i++) begin
            if (RW'(i) <= h_ff)
               order_ff[cmd_ff][i] <= order_ff[cmd_ff][i-1];
         end
         order_ff[cmd_ff][0] <= slot_ff;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_heard_count  = out_count_ff;
   assign rsp_entries_used = out_used_ff;

   // Checks.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff[0]) <= TABLE_ENTRIES && 32'(used_ff[1]) <= TABLE_ENTRIES)
      else $error("entry count above capacity");
   a_write_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |=> rsp_strobe)
      else $error("update without a result");
   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SRCH && rd_pend_ff |-> 32'(cmp_rank_ff) < TABLE_ENTRIES)
      else $error("walk past the table");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for heard_station_mtf_table_unit.
// Depends on hsmt_pkg (result codes, register indexes, match mask) and the unit itself.
module testbench;

   localparam int Depth = 32;
   localparam int Phases = 13;
   localparam int PerPhase = 100;
   localparam int PoolSize = 24;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] count;
      logic [5:0]  used;
   } heard_result_type;

   typedef struct {
      logic             cmd;
      logic [3:0]       iface;
      logic [55:0]      addr;
      logic [31:0]      now;
      bit               typed;
      heard_result_type res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = 1'b0;
   logic [3:0]  req_iface_id = '0;
   logic [55:0] req_station_addr = '0;
   logic [31:0] req_now_seconds = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_heard_count;
   logic [5:0]  rsp_entries_used;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Row-level expectation handed from the driver to the monitor.
   bit               row_typed = 1'b0;
   heard_result_type row_exp;

   // Shadow copies of the registers and both recency lists.
   logic        sh_skip_src = 1'b0;
   logic        sh_skip_dst = 1'b0;
   logic [15:0] sh_mask = '0;
   logic [5:0]  sh_max = '0;
   logic [55:0] list_addr [2][Depth];
   logic [3:0]  list_iface[2][Depth];
   logic [31:0] list_count[2][Depth];
   int          list_used [2] = '{0, 0};

   heard_result_type pending_results[$];
   int          failures = 0;
   int          mismatches = 0;

   heard_station_mtf_table_unit u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Each of the first six bytes, shifted right one, must be a letter, a digit or a space.
   function automatic bit callsign_ok(logic [55:0] a);
      logic [6:0] ch;
      for (int k = 0; k < 6; k++) begin
         ch = a[8*k+1 +: 7];
         if (!((ch >= 7'("A") && ch <= 7'("Z")) || (ch >= 7'("0") && ch <= 7'("9"))
               || ch == 7'(" ")))
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Applies one logging request to the shadow lists and returns its result.
   function automatic heard_result_type log_station(logic cmd, logic [3:0] ifc,
                                                    logic [55:0] a);
      heard_result_type r;
      int t, n, hit, last, lim;
      logic [55:0] ka;
      logic [3:0]  kf;
      logic [31:0] kc;
      t = int'(cmd);
      n = list_used[t];
      r.count = '0;
      r.used = 6'(n);
      if ((cmd ? sh_skip_dst : sh_skip_src) || !sh_mask[ifc]) begin
         r.status = hsmt_pkg::StatusFiltered;
         return r;
      end
      if (!callsign_ok(a)) begin
         r.status = hsmt_pkg::StatusInvalid;
         return r;
      end
      hit = n;
      for (int i = 0; i < n; i++)
         if (hit == n && list_iface[t][i] == ifc
             && ((list_addr[t][i] ^ a) & hsmt_pkg::MatchMask) == '0)
            hit = i;
      if (hit < n) begin
         ka = list_addr[t][hit];
         kf = list_iface[t][hit];
         kc = list_count[t][hit];
         last = hit;
         r.status = hsmt_pkg::StatusHit;
      end else begin
         lim = (sh_max == 6'd0 || int'(sh_max) > Depth) ? Depth : int'(sh_max);
         if (n >= lim) begin
            last = n - 1;
            r.status = hsmt_pkg::StatusReplace;
         end else begin
            last = n;
            n++;
            list_used[t] = n;
            r.status = hsmt_pkg::StatusNew;
         end
         ka = a;
         kf = ifc;
         kc = '0;
      end
      for (int i = last; i > 0; i--) begin
         list_addr[t][i]  = list_addr[t][i-1];
         list_iface[t][i] = list_iface[t][i-1];
         list_count[t][i] = list_count[t][i-1];
      end
      list_addr[t][0]  = ka;
      list_iface[t][0] = kf;
      list_count[t][0] = kc + 32'd1;
      r.count = kc + 32'd1;
      r.used = 6'(n);
      return r;
   endfunction

   // Monitor: tracks register writes, predicts each transfer and checks each result.
   always @(posedge clock) begin
      heard_result_type r;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               failures++;
               if (mismatches++ < 10)
                  $display("unexpected result: status %0d count %0d used %0d",
                           rsp_status, rsp_heard_count, rsp_entries_used);
            end else begin
               r = pending_results.pop_front();
               if (rsp_status !== r.status || rsp_heard_count !== r.count ||
                   rsp_entries_used !== r.used) begin
                  failures++;
                  if (mismatches++ < 10)
                     $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                              r.status, r.count, r.used,
                              rsp_status, rsp_heard_count, rsp_entries_used);
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               hsmt_pkg::RegSkipSource: sh_skip_src = csr_wdata[0];
               hsmt_pkg::RegSkipDest:   sh_skip_dst = csr_wdata[0];
               hsmt_pkg::RegIfaceMask:  sh_mask = csr_wdata;
               hsmt_pkg::RegMaxEntries: sh_max = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            r = log_station(req_cmd, req_iface_id, req_station_addr);
            if (row_typed)
               r = row_exp;
            pending_results.push_back(r);
         end
      end
   end

   // Builds a link address from up to six characters and a raw SSID byte.
   function automatic logic [55:0] call_addr(string s, logic [7:0] ssid_byte);
      logic [55:0] a;
      logic [7:0]  ch;
      for (int k = 0; k < 6; k++) begin
         ch = (k < s.len()) ? s[k] : " ";
         a[8*k +: 8] = {ch[6:0], 1'b0};
      end
      a[55:48] = ssid_byte;
      return a;
   endfunction

   function automatic logic [55:0] random_call();
      string       chars;
      logic [55:0] a;
      logic [7:0]  ch;
      chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 ";
      for (int k = 0; k < 6; k++) begin
         ch = chars[$urandom_range(36, 0)];
         a[8*k +: 8] = {ch[6:0], 1'($urandom_range(1, 0))};
      end
      a[55:48] = 8'($urandom);
      return a;
   endfunction

   function automatic stim_row_type mk(logic cmd, logic [3:0] ifc, logic [55:0] a,
                                       logic [31:0] now, bit typed,
                                       logic [2:0] st, logic [31:0] cnt, logic [5:0] used);
      stim_row_type r;
      r.cmd = cmd;
      r.iface = ifc;
      r.addr = a;
      r.now = now;
      r.typed = typed;
      r.res.status = st;
      r.res.count = cnt;
      r.res.used = used;
      return r;
   endfunction

   // Presents one command and holds it until the unit takes the transfer.
   task automatic send(stim_row_type r);
      @(negedge clock);
      start <= 1'b1;
      req_cmd <= r.cmd;
      req_iface_id <= r.iface;
      req_station_addr <= r.addr;
      req_now_seconds <= r.now;
      row_typed <= r.typed;
      row_exp <= r.res;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Waits until every expected result is in, then lets the unit settle.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Stimulus: directed rows first, then random phases under varied settings.
   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      logic [55:0] pool_addr [PoolSize];
      logic [3:0]  pool_iface[PoolSize];
      logic [5:0]  max_list[Phases] = '{0, 3, 32, 1, 33, 63, 8, 2, 0, 5, 16, 4, 0};
      int          pick, roll;
      bit          idling;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Logging is off for every interface right after reset.
      send(mk(0, 0, call_addr("N0CALL", 8'h60), 1, 1, hsmt_pkg::StatusFiltered, 0, 0));
      drain();
      write_reg(hsmt_pkg::RegIfaceMask, 16'hFFFF);

      rows.push_back(mk(0, 3, call_addr("N0CALL", 8'h62), 5, 1, hsmt_pkg::StatusNew, 1, 1));
      // Bits outside the SSID field of the last byte do not affect the match.
      rows.push_back(mk(0, 3, call_addr("N0CALL", 8'hE3), 6, 1, hsmt_pkg::StatusHit, 2, 1));
      rows.push_back(mk(0, 3, call_addr("N0CALL", 8'h64), 7, 1, hsmt_pkg::StatusNew, 1, 2));
      rows.push_back(mk(0, 4, call_addr("N0CALL", 8'h62), 8, 1, hsmt_pkg::StatusNew, 1, 3));
      rows.push_back(mk(0, 15, '1, '1, 1, hsmt_pkg::StatusInvalid, 0, 3));
      rows.push_back(mk(0, 0, '0, '0, 1, hsmt_pkg::StatusInvalid, 0, 3));
      rows.push_back(mk(0, 1, call_addr("@ZZZZZ", 8'h00), 9, 1, hsmt_pkg::StatusInvalid, 0, 3));
      rows.push_back(mk(0, 1, call_addr("AAAAA[", 8'h00), 9, 1, hsmt_pkg::StatusInvalid, 0, 3));
      rows.push_back(mk(0, 1, call_addr("/00000", 8'h00), 9, 1, hsmt_pkg::StatusInvalid, 0, 3));
      rows.push_back(mk(0, 1, call_addr("99:999", 8'h00), 9, 1, hsmt_pkg::StatusInvalid, 0, 3));
      rows.push_back(mk(1, 15, call_addr("      ", 8'hFF), '1, 1, hsmt_pkg::StatusNew, 1, 1));
      rows.push_back(mk(1, 0, call_addr("AZ09 Z", 8'h00), 0, 1, hsmt_pkg::StatusNew, 1, 2));
      rows.push_back(mk(0, 3, call_addr("N0CALL", 8'h62), 10, 1, hsmt_pkg::StatusHit, 3, 3));
      rows.push_back(mk(0, 4, call_addr("N0CALL", 8'h63), 11, 0, 0, 0, 0));
      rows.push_back(mk(1, 15, call_addr("      ", 8'h01), 12, 0, 0, 0, 0));
      foreach (rows[i])
         send(rows[i]);
      drain();

      for (int ph = 0; ph < Phases; ph++) begin
         idling = (ph < Phases - 2);
         write_reg(hsmt_pkg::RegSkipSource, 16'(ph % 5 == 3));
         write_reg(hsmt_pkg::RegSkipDest, 16'(ph % 6 == 4));
         write_reg(hsmt_pkg::RegIfaceMask, (ph % 4 == 2) ? 16'($urandom) : 16'hFFFF);
         write_reg(hsmt_pkg::RegMaxEntries, {10'd0, max_list[ph]});
         for (int i = 0; i < PoolSize; i++) begin
            pool_addr[i] = random_call();
            pool_iface[i] = 4'($urandom_range(3, 0)) | ((ph % 3 == 0) ? 4'($urandom) : 4'd0);
         end
         for (int n = 0; n < PerPhase; n++) begin
            roll = $urandom_range(99, 0);
            pick = $urandom_range(PoolSize - 1, 0);
            r = mk(1'($urandom_range(1, 0)), pool_iface[pick], pool_addr[pick], $urandom,
                   0, 0, 0, 0);
            if (roll < 12) begin
               r.addr = 56'({$urandom, $urandom});
               r.iface = 4'($urandom);
            end else if (roll < 20) begin
               r.addr[8*$urandom_range(5, 0) +: 8] = 8'($urandom);
            end else if (roll < 40) begin
               // Same station, other bits of the last byte changed.
               r.addr[55:53] = 3'($urandom);
               r.addr[48] = 1'($urandom_range(1, 0));
            end
            send(r);
            if (idling && $urandom_range(3, 0) == 0)
               pause($urandom_range(19, 1));
         end
         drain();
      end

      if (failures == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
